// File: rtl/assert_macros.svh
// Assertion macros shared by the modular square root RTL.
// Included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/msqrt_pkg.sv
// Package for the modular square root block: types, status codes, defaults.
// No dependencies.
`timescale 1ns / 1ps
package msqrt_pkg;
    localparam int unsigned DEF_MOD_WIDTH = 31;
    localparam int unsigned DEF_MAX_TRIES = 256;
    localparam int unsigned VAL_WIDTH     = 31;
    localparam int unsigned STAT_WIDTH    = 2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_ROOT = 2'd1,
        ST_GAVE_UP = 2'd2
    } status_t;

    // Modular multiply unit handshake.
    typedef struct packed {
        logic start;
    } mul_ctl_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_REDUCE,
        S_EUL_INIT,
        S_EUL_SQ,
        S_EUL_MUL,
        S_TRY_INIT,
        S_TRY_SQ,
        S_TRY_SUB,
        S_TRY_EUL,
        S_TRY_EUL_SQ,
        S_TRY_EUL_MUL,
        S_EXP_INIT,
        S_E_M1,
        S_E_M2,
        S_E_M3,
        S_E_M4,
        S_E_M5,
        S_E_COMB,
        S_E_NEXT,
        S_DONE
    } state_t;
endpackage

// File: rtl/msqrt_modmul.sv
// Bit-serial modular multiplier: one bit of the multiplier per cycle.
// Depends on msqrt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module msqrt_modmul
    import msqrt_pkg::*;
#(
    parameter int unsigned MOD_WIDTH = DEF_MOD_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mul_ctl_t             ctl,
    input  logic [MOD_WIDTH-1:0] a,
    input  logic [MOD_WIDTH-1:0] b,
    input  logic [MOD_WIDTH-1:0] m,
    output logic [MOD_WIDTH-1:0] prod,
    output logic                 busy
);
    logic [MOD_WIDTH-1:0] acc_reg, acc_next;
    logic [MOD_WIDTH-1:0] mcand_reg, mcand_next;
    logic [MOD_WIDTH-1:0] mplier_reg, mplier_next;
    logic                 busy_reg, busy_next;
    logic [MOD_WIDTH:0]   sum_ar, dbl;

    // Operands are already reduced below m.
    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        busy_next   = busy_reg;
        sum_ar      = {1'b0, acc_reg} + {1'b0, mcand_reg};
        dbl         = {mcand_reg, 1'b0};
        if (ctl.start)
        begin
            acc_next    = '0;
            mcand_next  = a;
            mplier_next = b;
            // a zero multiplier is finished as soon as it is loaded
            busy_next   = (b != '0);
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_next = (sum_ar >= {1'b0, m}) ? MOD_WIDTH'(sum_ar - {1'b0, m})
                                                 : sum_ar[MOD_WIDTH-1:0];
            mcand_next  = (dbl >= {1'b0, m}) ? MOD_WIDTH'(dbl - {1'b0, m})
                                             : dbl[MOD_WIDTH-1:0];
            mplier_next = mplier_reg >> 1;
            // advance until no multiplier bits remain
            busy_next   = (mplier_reg >> 1) != '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign prod = acc_reg;
    assign busy = busy_reg;

    `ASSERT_NEXT(a_mul_start, clk, rst_n, ctl.start && b != '0, busy_reg, "mul did not start")
    `ASSERT_IMPLIES(a_mul_zero, clk, rst_n, busy_reg, mplier_reg != '0, "busy with no bits")
endmodule

// File: rtl/msqrt_ctrl.sv
// Sequencer for Cipolla's method: reduction, Euler tests, search, extension power.
// Depends on msqrt_pkg, msqrt_modmul and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module msqrt_ctrl
    import msqrt_pkg::*;
#(
    parameter int unsigned MOD_WIDTH = DEF_MOD_WIDTH,
    parameter int unsigned MAX_TRIES = DEF_MAX_TRIES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [MOD_WIDTH-1:0] x_in,
    input  logic [MOD_WIDTH-1:0] p_in,
    output logic                 done,
    output logic [MOD_WIDTH-1:0] res_root,
    output status_t              res_status,
    input  logic                 ack
);
    localparam int unsigned TW = $clog2(MAX_TRIES + 1);
    localparam int unsigned CW = $clog2(MOD_WIDTH + 1);

    state_t state_reg, state_next;
    logic [MOD_WIDTH-1:0] x_reg, x_next, p_reg, p_next;
    logic [MOD_WIDTH-1:0] y_reg, y_next, w_reg, w_next;
    logic [MOD_WIDTH-1:0] r0_reg, r0_next, r1_reg, r1_next;
    logic [MOD_WIDTH-1:0] b0_reg, b0_next, b1_reg, b1_next;
    logic [MOD_WIDTH-1:0] t0_reg, t0_next, t1_reg, t1_next, t2_reg, t2_next;
    logic [MOD_WIDTH-1:0] e_reg, e_next, k_reg, k_next;
    logic [MOD_WIDTH:0]   rem_reg, rem_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [TW-1:0]        try_reg, try_next;
    logic                 mul_issued_reg, mul_issued_next;
    logic [MOD_WIDTH-1:0] res_root_reg, res_root_next;
    status_t              res_status_reg, res_status_next;

    mul_ctl_t             mctl;
    logic [MOD_WIDTH-1:0] ma, mb, mprod;
    logic                 mbusy;
    logic                 mul_done;
    logic [MOD_WIDTH:0]   sum_c, sub_y, rem_sh;
    logic [MOD_WIDTH-1:0] w_cand;

    msqrt_modmul #(.MOD_WIDTH(MOD_WIDTH)) u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mctl),
        .a     (ma),
        .b     (mb),
        .m     (p_reg),
        .prod  (mprod),
        .busy  (mbusy)
    );

    // A multiply completes once issued and the unit has gone idle.
    assign mul_done = mul_issued_reg && !mbusy && !mctl.start;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:       if (start) state_next = S_REDUCE;
            S_REDUCE:
                if (cnt_reg == '0)
                    state_next = S_EUL_INIT;
            S_EUL_INIT:
                state_next = (x_reg == '0 || res_root_reg == '0 || p_reg <= MOD_WIDTH'(2))
                             ? S_DONE : S_EUL_SQ;
            S_EUL_SQ:     if (mul_done) state_next = S_EUL_MUL;
            S_EUL_MUL:
                if (mul_done)
                begin
                    if (e_reg == '0)
                        state_next = S_TRY_INIT;
                    else
                        state_next = S_EUL_SQ;
                end
            S_TRY_INIT:   state_next = (r0_reg != MOD_WIDTH'(1)) ? S_DONE : S_TRY_SQ;
            S_TRY_SQ:     if (mul_done) state_next = S_TRY_SUB;
            S_TRY_SUB:    state_next = S_TRY_EUL;
            S_TRY_EUL:    state_next = S_TRY_EUL_SQ;
            S_TRY_EUL_SQ: if (mul_done) state_next = S_TRY_EUL_MUL;
            S_TRY_EUL_MUL:
                if (mul_done && e_reg == '0)
                begin
                    if (r0_reg != MOD_WIDTH'(1))
                        state_next = S_EXP_INIT;
                    else if (try_reg == TW'(MAX_TRIES))
                        state_next = S_DONE;
                    else
                        state_next = S_TRY_SQ;
                end
                else if (mul_done)
                    state_next = S_TRY_EUL_SQ;
            S_EXP_INIT:   state_next = S_E_M1;
            S_E_M1:       if (mul_done) state_next = S_E_M2;
            S_E_M2:       if (mul_done) state_next = S_E_M3;
            S_E_M3:       if (mul_done) state_next = S_E_M4;
            S_E_M4:       if (mul_done) state_next = S_E_M5;
            S_E_M5:       if (mul_done) state_next = S_E_COMB;
            S_E_COMB:     state_next = S_E_NEXT;
            S_E_NEXT:     state_next = (k_reg == '0) ? S_DONE : S_E_M1;
            S_DONE:       if (ack) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // Datapath and multiplier operand selection
    always_comb
    begin
        x_next = x_reg; p_next = p_reg; y_next = y_reg; w_next = w_reg;
        r0_next = r0_reg; r1_next = r1_reg; b0_next = b0_reg; b1_next = b1_reg;
        t0_next = t0_reg; t1_next = t1_reg; t2_next = t2_reg;
        e_next = e_reg; k_next = k_reg; rem_next = rem_reg; cnt_next = cnt_reg;
        try_next = try_reg;
        res_root_next = res_root_reg; res_status_next = res_status_reg;
        mctl.start = 1'b0;
        ma = '0;
        mb = '0;
        mul_issued_next = mul_issued_reg;
        sum_c  = '0;
        sub_y  = '0;
        rem_sh = {rem_reg[MOD_WIDTH-1:0], x_reg[MOD_WIDTH-1]};
        w_cand = '0;
        if (mul_done)
            mul_issued_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
                if (start)
                begin
                    x_next = x_in;
                    p_next = p_in;
                    rem_next = '0;
                    cnt_next = CW'(MOD_WIDTH);
                    res_status_next = ST_OK;
                    res_root_next = x_in;
                    // trivial cases finish straight after reduction is skipped
                    if (x_in == '0 || p_in <= MOD_WIDTH'(2))
                        cnt_next = '0;
                end
            S_REDUCE:
                // restoring reduction of x modulo p, one bit per cycle
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - CW'(1);
                    if (rem_sh >= {1'b0, p_reg})
                        rem_next = rem_sh - {1'b0, p_reg};
                    else
                        rem_next = rem_sh;
                    x_next = {x_reg[MOD_WIDTH-2:0], 1'b0};
                end
                else if (!(res_root_reg == '0 || p_reg <= MOD_WIDTH'(2)))
                    x_next = rem_reg[MOD_WIDTH-1:0];
            S_EUL_INIT:
            begin
                if (res_root_reg == '0 || p_reg <= MOD_WIDTH'(2))
                    x_next = '0;
                if (x_reg == '0)
                    res_root_next = (res_root_reg == '0 || p_reg <= MOD_WIDTH'(2))
                                    ? res_root_reg : '0;
                r0_next = MOD_WIDTH'(1);
                b0_next = x_reg;
                e_next  = (p_reg - MOD_WIDTH'(1)) >> 1;
            end
            S_EUL_SQ, S_TRY_EUL_SQ:
            begin
                ma = r0_reg;
                mb = b0_reg;
                if (!mul_issued_reg)
                begin
                    if (e_reg[0])
                    begin
                        mctl.start = 1'b1;
                        mul_issued_next = 1'b1;
                    end
                    else
                        mul_issued_next = 1'b1;
                end
                if (mul_done && e_reg[0])
                    r0_next = mprod;
            end
            S_EUL_MUL, S_TRY_EUL_MUL:
            begin
                ma = b0_reg;
                mb = b0_reg;
                if (!mul_issued_reg)
                begin
                    mctl.start = 1'b1;
                    mul_issued_next = 1'b1;
                end
                if (mul_done)
                begin
                    b0_next = mprod;
                    e_next  = e_reg >> 1;
                end
            end
            S_TRY_INIT:
            begin
                if (r0_reg != MOD_WIDTH'(1))
                begin
                    res_status_next = ST_NO_ROOT;
                    res_root_next = '0;
                end
                try_next = '0;
            end
            S_TRY_SQ:
            begin
                // w = t mod p; t is at most MAX_TRIES so one subtract loop is not
                // enough in general: track w as a counter wrapping at p
                if (try_reg == '0)
                    w_cand = MOD_WIDTH'(1);
                else
                    w_cand = (w_reg + MOD_WIDTH'(1) == p_reg) ? '0 : w_reg + MOD_WIDTH'(1);
                ma = w_cand;
                mb = w_cand;
                if (!mul_issued_reg)
                begin
                    mctl.start = 1'b1;
                    mul_issued_next = 1'b1;
                    w_next = w_cand;
                    try_next = try_reg + TW'(1);
                end
                else
                begin
                    ma = w_reg;
                    mb = w_reg;
                end
                if (mul_done)
                    t0_next = mprod;
            end
            S_TRY_SUB:
            begin
                sub_y = (t0_reg >= x_reg) ? {1'b0, t0_reg} - {1'b0, x_reg}
                                          : {1'b0, t0_reg} + {1'b0, p_reg} - {1'b0, x_reg};
                y_next = sub_y[MOD_WIDTH-1:0];
            end
            S_TRY_EUL:
            begin
                r0_next = MOD_WIDTH'(1);
                b0_next = y_reg;
                e_next  = (p_reg - MOD_WIDTH'(1)) >> 1;
            end
            S_EXP_INIT:
            begin
                r0_next = MOD_WIDTH'(1);
                r1_next = '0;
                b0_next = w_reg;
                b1_next = (p_reg > MOD_WIDTH'(1)) ? MOD_WIDTH'(1) : '0;
                k_next  = (p_reg >> 1) + MOD_WIDTH'(1);
            end
            // one step: if k odd, r *= b, else b *= b (b1*b1*y done through t regs)
            S_E_M1:
            begin
                // t0 = a0*b0, a = (k odd ? r : b)
                ma = k_reg[0] ? r0_reg : b0_reg;
                mb = b0_reg;
                if (!mul_issued_reg) begin mctl.start = 1'b1; mul_issued_next = 1'b1; end
                if (mul_done) t0_next = mprod;
            end
            S_E_M2:
            begin
                ma = k_reg[0] ? r1_reg : b1_reg;
                mb = b1_reg;
                if (!mul_issued_reg) begin mctl.start = 1'b1; mul_issued_next = 1'b1; end
                if (mul_done) t1_next = mprod;
            end
            S_E_M3:
            begin
                ma = t1_reg;
                mb = y_reg;
                if (!mul_issued_reg) begin mctl.start = 1'b1; mul_issued_next = 1'b1; end
                if (mul_done) t1_next = mprod;
            end
            S_E_M4:
            begin
                ma = k_reg[0] ? r0_reg : b0_reg;
                mb = b1_reg;
                if (!mul_issued_reg) begin mctl.start = 1'b1; mul_issued_next = 1'b1; end
                if (mul_done) t2_next = mprod;
            end
            S_E_M5:
            begin
                ma = k_reg[0] ? r1_reg : b1_reg;
                mb = b0_reg;
                if (!mul_issued_reg) begin mctl.start = 1'b1; mul_issued_next = 1'b1; end
                if (mul_done) e_next = mprod;
            end
            S_E_COMB:
            begin
                sum_c = {1'b0, t0_reg} + {1'b0, t1_reg};
                t0_next = (sum_c >= {1'b0, p_reg}) ? MOD_WIDTH'(sum_c - {1'b0, p_reg})
                                                   : sum_c[MOD_WIDTH-1:0];
                sub_y = {1'b0, t2_reg} + {1'b0, e_reg};
                t1_next = (sub_y >= {1'b0, p_reg}) ? MOD_WIDTH'(sub_y - {1'b0, p_reg})
                                                   : sub_y[MOD_WIDTH-1:0];
            end
            S_E_NEXT:
            begin
                // commit the product to r when k was odd, else it was b squared
                if (k_reg[0])
                begin
                    r0_next = t0_reg;
                    r1_next = t1_reg;
                    k_next  = k_reg & ~MOD_WIDTH'(1);
                end
                else
                begin
                    b0_next = t0_reg;
                    b1_next = t1_reg;
                    k_next  = k_reg >> 1;
                end
                if (k_reg == '0)
                    res_root_next = r0_reg;
            end
            S_DONE: ;
            default: ;
        endcase

        // status on the exit from the search when it gives up
        if (state_reg == S_TRY_EUL_MUL && mul_done && e_reg == '0
            && r0_reg == MOD_WIDTH'(1) && try_reg == TW'(MAX_TRIES))
        begin
            res_status_next = ST_GAVE_UP;
            res_root_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mul_issued_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mul_issued_reg <= mul_issued_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next; p_reg <= p_next; y_reg <= y_next; w_reg <= w_next;
        r0_reg <= r0_next; r1_reg <= r1_next; b0_reg <= b0_next; b1_reg <= b1_next;
        t0_reg <= t0_next; t1_reg <= t1_next; t2_reg <= t2_next;
        e_reg <= e_next; k_reg <= k_next; rem_reg <= rem_next; cnt_reg <= cnt_next;
        try_reg <= try_next;
        res_root_reg <= res_root_next; res_status_reg <= res_status_next;
    end

    assign done       = (state_reg == S_DONE);
    assign res_root   = res_root_reg;
    assign res_status = res_status_reg;

    `ASSERT_IMPLIES(a_done_root, clk, rst_n, state_reg == S_DONE && res_status_reg != ST_OK, res_root_reg == '0, "root nonzero on failure")
    `ASSERT_IMPLIES(a_idle_mul, clk, rst_n, state_reg == S_IDLE, !mbusy, "multiplier busy while idle")
    `ASSERT_IMPLIES(a_try_bound, clk, rst_n, state_reg != S_IDLE, try_reg <= TW'(MAX_TRIES), "try count past limit")
endmodule

// File: rtl/modular_square_root.sv
// Top level of the modular square root block (Cipolla's method).
// Depends on msqrt_pkg and msqrt_ctrl.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_valid/in_stall carries value and modulus (prime, 31 bits).
//   Output channel out_valid/out_stall carries root and status.
//   status 0: root found, 1: value is a non-residue, 2: search gave up.
//   One request is worked on at a time; in_stall is high from acceptance until
//   the result is taken, so a new request is accepted the cycle after that.
//   A zero value or modulus at most 2 skips reduction; a value that
//   reduces to zero ends after reduction. Others take one Euler test (up to
//   2*MOD_WIDTH multiplies), one square plus one test per search candidate,
//   and an extension power of up to 2*MOD_WIDTH steps of five multiplies.
//   Every multiply is bit serial, one multiplier bit per cycle, on a single
//   multiplier shared by all steps.
//   The result is held on the output until taken; out_stall freezes it and
//   the block accepts no new request until then.
//   Reset clears the sequencer to idle with no result pending.
module modular_square_root
    import msqrt_pkg::*;
#(
    parameter int unsigned MOD_WIDTH = DEF_MOD_WIDTH,
    parameter int unsigned MAX_TRIES = DEF_MAX_TRIES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [VAL_WIDTH-1:0]  value,
    input  logic [VAL_WIDTH-1:0]  modulus,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [VAL_WIDTH-1:0]  root,
    output logic [STAT_WIDTH-1:0] status
);
    logic                 busy_reg, busy_next;
    logic                 start, done, ack;
    logic [MOD_WIDTH-1:0] res_root;
    status_t              res_status;
    logic [MOD_WIDTH-1:0] x_in, p_in;

    always_comb
    begin
        x_in = '0;
        p_in = '0;
        for (int i = 0; i < MOD_WIDTH; i++)
        begin
            if (i < VAL_WIDTH)
            begin
                x_in[i] = value[i];
                p_in[i] = modulus[i];
            end
        end
    end

    assign start = in_valid && !busy_reg;
    assign ack   = done && !out_stall;

    always_comb
    begin
        busy_next = busy_reg;
        if (start)
            busy_next = 1'b1;
        else if (ack)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    msqrt_ctrl #(.MOD_WIDTH(MOD_WIDTH), .MAX_TRIES(MAX_TRIES)) u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .x_in       (x_in),
        .p_in       (p_in),
        .done       (done),
        .res_root   (res_root),
        .res_status (res_status),
        .ack        (ack)
    );

    always_comb
    begin
        root = '0;
        for (int i = 0; i < VAL_WIDTH; i++)
        begin
            if (i < MOD_WIDTH)
                root[i] = res_root[i];
        end
    end

    assign in_stall  = busy_reg;
    assign out_valid = done;
    assign status    = STAT_WIDTH'(res_status);
endmodule

// File: test/modular_square_root_checker.sv
// Checker for the modular square root block: watches both channels, predicts each
// root with its own Cipolla computation and compares field by field.
// Depends on msqrt_pkg.
`timescale 1ns / 1ps
module modular_square_root_checker
    import msqrt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [VAL_WIDTH-1:0]  value,
    input  logic [VAL_WIDTH-1:0]  modulus,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [VAL_WIDTH-1:0]  root,
    input  logic [STAT_WIDTH-1:0] status,
    output int                    errors,
    output int                    pending,
    output int                    checked,
    output int                    n_found,
    output int                    n_no_root,
    output int                    n_gave_up
);
    typedef longint unsigned u64;

    typedef struct {
        logic [VAL_WIDTH-1:0] root;
        status_t              status;
    } sqrt_result_t;

    sqrt_result_t expected_roots[$];

    function automatic u64 mul_mod(u64 a, u64 b, u64 m);
        return ((a % m) * (b % m)) % m;
    endfunction

    function automatic u64 pow_mod(u64 b, u64 e, u64 m);
        u64 r;
        r = 1;
        b = b % m;
        while (e != 0)
        begin
            if (e[0])
                r = mul_mod(r, b, m);
            b = mul_mod(b, b, m);
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic sqrt_result_t cipolla_root(logic [VAL_WIDTH-1:0] xv,
                                                  logic [VAL_WIDTH-1:0] pv);
        sqrt_result_t res;
        u64 x, p, half, w, y, ww, r0, r1, b0, b1, c0, c1, k;
        bit found;
        x = xv;
        p = pv;
        res.root = '0;
        res.status = ST_OK;
        found = 0;
        w = 0;
        y = 0;
        if (x == 0 || p <= 2)
        begin
            res.root = xv;
            return res;
        end
        x = x % p;
        if (x == 0)
            return res;
        half = (p - 1) >> 1;
        if (pow_mod(x, half, p) != 1)
        begin
            res.status = ST_NO_ROOT;
            return res;
        end
        for (int t = 1; t <= DEF_MAX_TRIES && !found; t++)
        begin
            w = u64'(t) % p;
            ww = mul_mod(w, w, p);
            y = (ww >= x) ? ww - x : ww + p - x;
            if (pow_mod(y, half, p) != 1)
                found = 1;
        end
        if (!found)
        begin
            res.status = ST_GAVE_UP;
            return res;
        end
        // raise (w + sqrt(y)) to (p+1)/2 in the extension field
        r0 = 1;
        r1 = 0;
        b0 = w;
        b1 = 1;
        for (k = (p >> 1) + 1; k != 0; k = k >> 1)
        begin
            if (k[0])
            begin
                c0 = (mul_mod(r0, b0, p) + mul_mod(mul_mod(r1, b1, p), y, p)) % p;
                c1 = (mul_mod(r0, b1, p) + mul_mod(r1, b0, p)) % p;
                r0 = c0;
                r1 = c1;
            end
            c0 = (mul_mod(b0, b0, p) + mul_mod(mul_mod(b1, b1, p), y, p)) % p;
            c1 = (mul_mod(b0, b1, p) + mul_mod(b1, b0, p)) % p;
            b0 = c0;
            b1 = c1;
        end
        res.root = r0[VAL_WIDTH-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        errors++;
    endtask

    initial
    begin
        errors = 0;
        checked = 0;
        n_found = 0;
        n_no_root = 0;
        n_gave_up = 0;
    end

    assign pending = expected_roots.size();

    always @(posedge clk)
    begin
        sqrt_result_t exp_res;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_roots.push_back(cipolla_root(value, modulus));
            if (out_valid && !out_stall)
            begin
                if (expected_roots.size() == 0)
                    report_mismatch($sformatf("unexpected result root=%0d status=%0d",
                                              root, status));
                else
                begin
                    exp_res = expected_roots.pop_front();
                    checked++;
                    case (exp_res.status)
                        ST_OK:      n_found++;
                        ST_NO_ROOT: n_no_root++;
                        default:    n_gave_up++;
                    endcase
                    if (status !== exp_res.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, exp_res.status));
                    if (root !== exp_res.root)
                        report_mismatch($sformatf("root %0d, expected %0d",
                                                  root, exp_res.root));
                end
            end
        end
    end
endmodule

// File: test/modular_square_root_test.sv
// Testbench top for the modular square root block: clock, reset, request and
// result stimulus with random gaps and stalls; verdict. Depends on msqrt_pkg,
// modular_square_root and modular_square_root_checker.
`timescale 1ns / 1ps
module modular_square_root_test;
    import msqrt_pkg::*;

    localparam int unsigned RANDOM_REQUESTS = 530;
    localparam longint     CYCLE_LIMIT     = 2_000_000_000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [VAL_WIDTH-1:0]  value;
    logic [VAL_WIDTH-1:0]  modulus;
    logic                  out_valid;
    logic                  out_stall;
    logic [VAL_WIDTH-1:0]  root;
    logic [STAT_WIDTH-1:0] status;
    int                    errors, pending, checked, n_found, n_no_root, n_gave_up;
    longint                cycles;
    bit                    sending_done;

    modular_square_root DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .value(value), .modulus(modulus),
        .out_valid(out_valid), .out_stall(out_stall), .root(root), .status(status)
    );

    modular_square_root_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .value(value), .modulus(modulus),
        .out_valid(out_valid), .out_stall(out_stall), .root(root), .status(status),
        .errors(errors), .pending(pending), .checked(checked),
        .n_found(n_found), .n_no_root(n_no_root), .n_gave_up(n_gave_up)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("modular_square_root test failed");
                $finish;
            end
        end
    end

    function automatic int random_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        else if (roll < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    function automatic bit is_prime(longint unsigned n);
        if (n < 2)
            return 0;
        if (n < 4)
            return 1;
        if (n[0] == 0)
            return 0;
        for (longint unsigned d = 3; d * d <= n; d += 2)
            if (n % d == 0)
                return 0;
        return 1;
    endfunction

    function automatic longint unsigned random_prime();
        longint unsigned n;
        int bits;
        bits = $urandom_range(2, 31);
        do
            n = $urandom_range(0, (32'h1 << bits) - 1) | 1;
        while (!is_prime(n));
        return n;
    endfunction

    task automatic send_request(logic [VAL_WIDTH-1:0] v, logic [VAL_WIDTH-1:0] m);
        int gap;
        gap = random_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        modulus  <= m;
        // hold until the request is taken
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_random_request();
        longint unsigned p, x, r;
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 70)
            p = random_prime();
        else if (kind < 85)
            p = $urandom_range(3, 32'h7fff_ffff);
        else
            p = $urandom_range(0, 40);
        if (p == 0)
            x = $urandom_range(0, 32'h7fff_ffff);
        else if ($urandom_range(0, 99) < 55)
        begin
            // a true square gives the root path most of the time
            r = $urandom_range(0, 32'h7fff_ffff) % p;
            x = (r * r) % p;
        end
        else if ($urandom_range(0, 99) < 85)
            x = $urandom_range(0, 32'h7fff_ffff) % p;
        else
            x = $urandom_range(0, 32'h7fff_ffff);
        send_request(x[VAL_WIDTH-1:0], p[VAL_WIDTH-1:0]);
    endtask

    // result side: random stalls, one long hold-off after the first hundred results
    initial
    begin
        bit held;
        held = 0;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && checked >= 100)
            begin
                held = 1;
                out_stall <= 1'b1;
                repeat (40000) @(negedge clk);
            end
            else if ($urandom_range(0, 99) < 40)
                out_stall <= 1'b0;
            else if ($urandom_range(0, 99) < 90)
            begin
                out_stall <= 1'b1;
                repeat (random_gap()) @(negedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        logic [VAL_WIDTH-1:0] dir_val[$];
        logic [VAL_WIDTH-1:0] dir_mod[$];
        int unsigned drain;
        in_valid = 1'b0;
        value = '0;
        modulus = '0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // pass-through, reduction, residues, non-residues, extremes, composites
        dir_val = '{0, 5, 5, 3, 31'h7fff_ffff, 10, 14, 31'h7fff_fffe, 2, 4, 1, 2, 4, 3,
                    8, 1, 4, 31'h7fff_ffff, 1, 3, 0, 31'h5555_5555, 31'h2aaa_aaaa, 9};
        dir_mod = '{7, 0, 1, 2, 2, 7, 7, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff,
                    3, 3, 5, 5, 15, 9, 13, 31'h7fff_ffff, 4, 4, 31'h7fff_ffff,
                    31'h7fff_ffff, 31'h7fff_ffff, 25};
        foreach (dir_val[i])
            send_request(dir_val[i], dir_mod[i]);

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n == RANDOM_REQUESTS / 2)
            begin
                // drain completely before going on
                @(negedge clk);
                in_valid <= 1'b0;
                wait (pending == 0);
            end
            send_random_request();
        end
        @(negedge clk);
        in_valid <= 1'b0;

        wait (pending == 0);
        drain = 0;
        while (drain < 2000)
        begin
            @(posedge clk);
            drain++;
        end
        $display("checked %0d results: %0d roots, %0d non-residues, %0d gave up",
                 checked, n_found, n_no_root, n_gave_up);
        $display("directed edge cases plus random primes and composites, %0d cycles",
                 cycles);
        if (errors == 0)
            $display("modular_square_root test passed");
        else
            $display("modular_square_root test failed");
        $finish;
    end
endmodule
